// ===== hw/rtl/asdx_pkg.sv =====
package asdx_pkg;

    localparam int MAX_FRAME_DEF  = 256;
    localparam int MAX_FIELDS_DEF = 16;

    localparam int NUM_SLOTS  = 4;
    localparam int NUM_REGS   = 8;
    localparam int CFG_IDX_W  = 4;
    localparam int CFG_DATA_W = 24;
    localparam int TYPE_W     = 24;
    localparam int ARG_W      = 4;

    localparam logic [7:0] CH_DOLLAR  = 8'h24;
    localparam logic [7:0] CH_NEWLINE = 8'h0A;
    localparam logic [7:0] CH_COMMA   = 8'h2C;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_TYPE_CODE_A = 4'd0,
        REG_TYPE_CODE_B = 4'd1,
        REG_TYPE_CODE_C = 4'd2,
        REG_TYPE_CODE_D = 4'd3,
        REG_ARG_COUNT_A = 4'd4,
        REG_ARG_COUNT_B = 4'd5,
        REG_ARG_COUNT_C = 4'd6,
        REG_ARG_COUNT_D = 4'd7
    } reg_idx_t;

    localparam logic [ARG_W-1:0] ARG_COUNT_A_RST = 4'd1;
    localparam logic [ARG_W-1:0] ARG_COUNT_B_RST = 4'd10;
    localparam logic [ARG_W-1:0] ARG_COUNT_C_RST = 4'd10;
    localparam logic [ARG_W-1:0] ARG_COUNT_D_RST = 4'd3;

    typedef enum logic [1:0] {
        PH_HUNT = 2'd0,
        PH_TYPE = 2'd1,
        PH_BODY = 2'd2
    } phase_t;

    typedef enum logic [2:0] {
        ST_OK       = 3'd0,
        ST_CHECKSUM = 3'd1,
        ST_COUNT    = 3'd2,
        ST_UNKNOWN  = 3'd3,
        ST_OVERFLOW = 3'd4
    } status_t;

    localparam logic KIND_BODY = 1'b0;
    localparam logic KIND_END  = 1'b1;

    typedef struct packed {
        logic [NUM_SLOTS-1:0][TYPE_W-1:0] type_code;
        logic [NUM_SLOTS-1:0][ARG_W-1:0]  arg_count;
    } cfg_t;

    typedef struct packed {
        logic       item_kind;
        logic [7:0] body_byte;
        logic [3:0] field_index;
        logic [1:0] type_slot;
        status_t    frame_status;
        logic [4:0] field_total;
        logic [7:0] calc_checksum;
        logic [7:0] sent_checksum;
        logic       frame_last;
    } res_t;

    typedef struct packed {
        logic valid;
        res_t data;
    } push_t;

endpackage

// ===== hw/rtl/asdx_if.sv =====
interface asdx_byte_if;
    import asdx_pkg::*;
    logic       valid;
    logic       ready;
    logic [7:0] rx_byte;
    modport source (output valid, output rx_byte, input ready);
    modport sink (input valid, input rx_byte, output ready);
endinterface

interface asdx_result_if;
    import asdx_pkg::*;
    logic       valid;
    logic       ready;
    logic       item_kind;
    logic [7:0] body_byte;
    logic [3:0] field_index;
    logic [1:0] type_slot;
    logic [2:0] frame_status;
    logic [4:0] field_total;
    logic [7:0] calc_checksum;
    logic [7:0] sent_checksum;
    logic       frame_last;
    modport source (output valid, output item_kind, output body_byte, output field_index,
                    output type_slot, output frame_status, output field_total,
                    output calc_checksum, output sent_checksum, output frame_last,
                    input ready);
    modport sink (input valid, input item_kind, input body_byte, input field_index,
                  input type_slot, input frame_status, input field_total,
                  input calc_checksum, input sent_checksum, input frame_last,
                  output ready);
endinterface

interface asdx_cfg_if;
    import asdx_pkg::*;
    logic                  valid;
    logic                  ready;
    logic [CFG_IDX_W-1:0]  index;
    logic [CFG_DATA_W-1:0] data;
    modport source (output valid, output index, output data, input ready);
    modport sink (input valid, input index, input data, output ready);
endinterface

// ===== hw/rtl/asdx_cfg_regs.sv =====
module asdx_cfg_regs
    import asdx_pkg::*;
(
    input  logic   clk,
    input  logic   rst_n,
    asdx_cfg_if.sink cfg,
    output cfg_t   cfg_out
);

    cfg_t regs_reg;
    cfg_t regs_next;
    logic wr_en;

    assign cfg.ready = 1'b1;
    assign wr_en     = cfg.valid && cfg.ready;
    assign cfg_out   = regs_reg;

    always_comb
    begin
        regs_next = regs_reg;
        if (wr_en)
        begin
            unique case (cfg.index)
                REG_TYPE_CODE_A: regs_next.type_code[0] = cfg.data;
                REG_TYPE_CODE_B: regs_next.type_code[1] = cfg.data;
                REG_TYPE_CODE_C: regs_next.type_code[2] = cfg.data;
                REG_TYPE_CODE_D: regs_next.type_code[3] = cfg.data;
                REG_ARG_COUNT_A: regs_next.arg_count[0] = cfg.data[ARG_W-1:0];
                REG_ARG_COUNT_B: regs_next.arg_count[1] = cfg.data[ARG_W-1:0];
                REG_ARG_COUNT_C: regs_next.arg_count[2] = cfg.data[ARG_W-1:0];
                REG_ARG_COUNT_D: regs_next.arg_count[3] = cfg.data[ARG_W-1:0];
                default:         regs_next = regs_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            regs_reg.type_code    <= '0;
            regs_reg.arg_count[0] <= ARG_COUNT_A_RST;
            regs_reg.arg_count[1] <= ARG_COUNT_B_RST;
            regs_reg.arg_count[2] <= ARG_COUNT_C_RST;
            regs_reg.arg_count[3] <= ARG_COUNT_D_RST;
        end
        else
        begin
            regs_reg <= regs_next;
        end
    end

endmodule

// ===== hw/rtl/asdx_front.sv =====
module asdx_front
    import asdx_pkg::*;
#(
    parameter int MAX_FRAME  = MAX_FRAME_DEF,
    parameter int MAX_FIELDS = MAX_FIELDS_DEF
)
(
    input  logic  clk,
    input  logic  rst_n,
    asdx_byte_if.sink rx,
    input  logic  queue_full,
    input  cfg_t  cfg_in,
    output push_t push
);

    localparam int POS_W = $clog2(MAX_FRAME + 2);
    localparam int FLD_W = $clog2(MAX_FIELDS + 1);

    function automatic logic [4:0] hex_decode(input logic [7:0] b);
        logic [4:0] r;
        r = 5'b0;
        if (b >= 8'h30 && b <= 8'h39)
            r = {1'b1, 4'(b - 8'h30)};
        else if (b >= 8'h61 && b <= 8'h66)
            r = {1'b1, 4'(b - 8'h57)};
        else if (b >= 8'h41 && b <= 8'h46)
            r = {1'b1, 4'(b - 8'h37)};
        return r;
    endfunction

    phase_t            phase_reg, phase_next;
    logic [TYPE_W-1:0] type_reg, type_next;
    logic [POS_W-1:0]  pos_reg, pos_next;
    logic [FLD_W-1:0]  fcnt_reg, fcnt_next;
    logic              hit_reg, hit_next;
    logic [1:0]        slot_reg, slot_next;
    logic [7:0]        xor_reg, xor_next;
    logic [7:0]        xor_comma_reg, xor_comma_next;
    logic [7:0]        hex_reg, hex_next;
    logic              hex_stop_reg, hex_stop_next;

    logic              accept;
    logic [7:0]        b;
    logic [4:0]        hex_d;
    logic [POS_W-1:0]  pos_inc;
    logic [7:0]        calc;
    logic [NUM_SLOTS-1:0] match;

    assign rx.ready = !queue_full;
    assign accept   = rx.valid && rx.ready;
    assign b        = rx.rx_byte;
    assign hex_d    = hex_decode(b);
    assign pos_inc  = (pos_reg <= POS_W'(MAX_FRAME)) ? pos_reg + POS_W'(1) : pos_reg;
    assign calc     = (fcnt_reg == '0) ? xor_reg : xor_comma_reg;

    always_comb
    begin
        for (int s = 0; s < NUM_SLOTS; s++)
            match[s] = (type_reg == cfg_in.type_code[s]);
    end

    always_comb
    begin
        phase_next = phase_reg;
        if (accept)
        begin
            unique case (phase_reg)
                PH_HUNT: phase_next = (b == CH_DOLLAR) ? PH_TYPE : PH_HUNT;
                PH_TYPE: phase_next = (pos_reg == POS_W'(3)) ? PH_BODY : PH_TYPE;
                PH_BODY: phase_next = (b == CH_NEWLINE) ? PH_HUNT : PH_BODY;
                default: phase_next = PH_HUNT;
            endcase
        end
    end

    always_comb
    begin
        type_next      = type_reg;
        pos_next       = pos_reg;
        fcnt_next      = fcnt_reg;
        hit_next       = hit_reg;
        slot_next      = slot_reg;
        xor_next       = xor_reg;
        xor_comma_next = xor_comma_reg;
        hex_next       = hex_reg;
        hex_stop_next  = hex_stop_reg;
        push           = '0;
        push.data.frame_status = ST_OK;

        if (accept)
        begin
            unique case (phase_reg)
                PH_TYPE:
                begin
                    if (pos_reg != POS_W'(3))
                    begin
                        type_next = {type_reg[TYPE_W-9:0], b};
                        pos_next  = pos_reg + POS_W'(1);
                    end
                    else
                    begin
                        hit_next  = |match;
                        slot_next = match[0] ? 2'd0 : match[1] ? 2'd1 :
                                    match[2] ? 2'd2 : 2'd3;
                        xor_next  = type_reg[23:16] ^ type_reg[15:8] ^ type_reg[7:0]
                                    ^ CH_COMMA;
                        xor_comma_next = '0;
                        hex_next       = '0;
                        hex_stop_next  = 1'b0;
                        fcnt_next      = '0;
                        pos_next       = '0;
                    end
                end
                PH_BODY:
                begin
                    if (b == CH_NEWLINE)
                    begin
                        push.valid               = 1'b1;
                        push.data.item_kind      = KIND_END;
                        push.data.type_slot      = hit_reg ? slot_reg : 2'd0;
                        push.data.field_total    = (int'(fcnt_reg) >= 15) ? 5'd16 :
                                                   5'(fcnt_reg) + 5'd1;
                        push.data.calc_checksum  = calc;
                        push.data.sent_checksum  = hex_reg;
                        push.data.frame_last     = 1'b1;
                        if (!hit_reg)
                            push.data.frame_status = ST_UNKNOWN;
                        else if (pos_reg > POS_W'(MAX_FRAME))
                            push.data.frame_status = ST_OVERFLOW;
                        else if (int'(fcnt_reg) != int'(cfg_in.arg_count[slot_reg]))
                            push.data.frame_status = ST_COUNT;
                        else if (calc != hex_reg)
                            push.data.frame_status = ST_CHECKSUM;
                    end
                    else if (b == CH_COMMA)
                    begin
                        pos_next       = pos_inc;
                        xor_comma_next = xor_reg;
                        xor_next       = xor_reg ^ CH_COMMA;
                        if (fcnt_reg < FLD_W'(MAX_FIELDS))
                            fcnt_next = fcnt_reg + FLD_W'(1);
                        hex_next      = '0;
                        hex_stop_next = 1'b0;
                    end
                    else
                    begin
                        pos_next = pos_inc;
                        xor_next = xor_reg ^ b;
                        if (!hex_stop_reg)
                        begin
                            if (hex_d[4])
                                hex_next = {hex_reg[3:0], hex_d[3:0]};
                            else
                                hex_stop_next = 1'b1;
                        end
                        if (hit_reg && pos_inc <= POS_W'(MAX_FRAME))
                        begin
                            push.valid            = 1'b1;
                            push.data.item_kind   = KIND_BODY;
                            push.data.body_byte   = b;
                            push.data.field_index = (int'(fcnt_reg) > 15) ? 4'd15 :
                                                    4'(fcnt_reg);
                            push.data.type_slot   = slot_reg;
                        end
                    end
                end
                default:
                begin
                    if (b == CH_DOLLAR)
                    begin
                        type_next      = '0;
                        pos_next       = '0;
                        fcnt_next      = '0;
                        hit_next       = 1'b0;
                        slot_next      = '0;
                        xor_next       = '0;
                        xor_comma_next = '0;
                        hex_next       = '0;
                        hex_stop_next  = 1'b0;
                    end
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg     <= PH_HUNT;
            type_reg      <= '0;
            pos_reg       <= '0;
            fcnt_reg      <= '0;
            hit_reg       <= 1'b0;
            slot_reg      <= '0;
            xor_reg       <= '0;
            xor_comma_reg <= '0;
            hex_reg       <= '0;
            hex_stop_reg  <= 1'b0;
        end
        else
        begin
            phase_reg     <= phase_next;
            type_reg      <= type_next;
            pos_reg       <= pos_next;
            fcnt_reg      <= fcnt_next;
            hit_reg       <= hit_next;
            slot_reg      <= slot_next;
            xor_reg       <= xor_next;
            xor_comma_reg <= xor_comma_next;
            hex_reg       <= hex_next;
            hex_stop_reg  <= hex_stop_next;
        end
    end

    a_push_on_accept: assert property (@(posedge clk) disable iff (!rst_n)
        push.valid |-> accept)
        else $error("front pushed without an accepted transaction");

    a_end_to_hunt: assert property (@(posedge clk) disable iff (!rst_n)
        (push.valid && push.data.item_kind == KIND_END) |=> phase_reg == PH_HUNT)
        else $error("frame end did not return to hunting");

    a_body_in_frame: assert property (@(posedge clk) disable iff (!rst_n)
        (push.valid && push.data.item_kind == KIND_BODY) |-> (phase_reg == PH_BODY && hit_reg))
        else $error("body byte pushed outside a matched frame");

endmodule

// ===== hw/rtl/asdx_queue.sv =====
module asdx_queue
    import asdx_pkg::*;
(
    input  logic  clk,
    input  logic  rst_n,
    input  push_t push,
    output logic  full,
    asdx_result_if.source result
);

    localparam int DEPTH = 2;

    res_t       mem_reg [DEPTH];
    logic       wr_ptr_reg, wr_ptr_next;
    logic       rd_ptr_reg, rd_ptr_next;
    logic [1:0] count_reg, count_next;
    logic       pop;
    res_t       head;

    assign full = (count_reg == 2'(DEPTH));
    assign pop  = result.valid && result.ready;
    assign head = mem_reg[rd_ptr_reg];

    assign result.valid          = (count_reg != 2'd0);
    assign result.item_kind      = head.item_kind;
    assign result.body_byte      = head.body_byte;
    assign result.field_index    = head.field_index;
    assign result.type_slot      = head.type_slot;
    assign result.frame_status   = head.frame_status;
    assign result.field_total    = head.field_total;
    assign result.calc_checksum  = head.calc_checksum;
    assign result.sent_checksum  = head.sent_checksum;
    assign result.frame_last     = head.frame_last;

    always_comb
    begin
        wr_ptr_next = push.valid ? ~wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = pop ? ~rd_ptr_reg : rd_ptr_reg;
        count_next  = count_reg + 2'(push.valid) - 2'(pop);
    end

    always_ff @(posedge clk)
    begin
        if (push.valid)
            mem_reg[wr_ptr_reg] <= push.data;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= 2'(DEPTH))
        else $error("queue count out of range");

    a_no_push_full: assert property (@(posedge clk) disable iff (!rst_n)
        !(push.valid && full))
        else $error("push into a full queue");

    a_ptr_track: assert property (@(posedge clk) disable iff (!rst_n)
        (count_reg == 2'd0 || count_reg == 2'(DEPTH)) |-> wr_ptr_reg == rd_ptr_reg)
        else $error("queue pointers out of step with count");

endmodule

// ===== hw/rtl/ascii_sentence_deframer_xor_check_unit.sv =====
// ASCII sentence deframer with XOR checksum.
// rx: one received byte per transaction (valid/ready). result: body bytes of a
// matched frame tagged with field index and type slot, and one frame-end report
// per newline with status, field total and both checksums. cfg: register writes
// (index 0..3 type codes, 4..7 argument counts); always ready, index 8 and up
// ignored. Write configuration only while no frame is in flight.
// Throughput: one rx byte per cycle while the result queue has room. Each byte
// is handled in the front state machine in the cycle it is accepted; its result,
// if any, is available on the result channel the next cycle, from a two-entry queue.
// rx.ready drops only when that queue holds two results the receiver has not
// taken, so a stalled receiver stops the byte stream after two pending results
// and nothing is lost.
// Reset: the deframer returns to hunting for the start byte, the queue empties,
// type codes clear to zero and argument counts return to 1, 10, 10, 3.
module ascii_sentence_deframer_xor_check_unit
    import asdx_pkg::*;
#(
    parameter int MAX_FRAME  = MAX_FRAME_DEF,
    parameter int MAX_FIELDS = MAX_FIELDS_DEF
)
(
    input  logic clk,
    input  logic rst_n,
    asdx_byte_if.sink     rx,
    asdx_result_if.source result,
    asdx_cfg_if.sink      cfg
);

    cfg_t  cfg_q;
    push_t push;
    logic  queue_full;

    asdx_cfg_regs u_cfg_regs (
        .clk     (clk),
        .rst_n   (rst_n),
        .cfg     (cfg),
        .cfg_out (cfg_q)
    );

    asdx_front #(
        .MAX_FRAME  (MAX_FRAME),
        .MAX_FIELDS (MAX_FIELDS)
    ) u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .rx         (rx),
        .queue_full (queue_full),
        .cfg_in     (cfg_q),
        .push       (push)
    );

    asdx_queue u_queue (
        .clk    (clk),
        .rst_n  (rst_n),
        .push   (push),
        .full   (queue_full),
        .result (result)
    );

endmodule
